// File: sv/ntc_pkg.sv
// Package with format codes, operation codes and shared types of the converter.
package ntc_pkg;
	localparam int DataW = 32;
	localparam int TypeW = 3;
	localparam int CfgIdxW = 1;

	typedef enum logic [2:0] {
		T_U8  = 3'd0,
		T_I8  = 3'd1,
		T_U16 = 3'd2,
		T_I16 = 3'd3,
		T_U32 = 3'd4,
		T_I32 = 3'd5,
		T_F16 = 3'd6,
		T_F32 = 3'd7
	} fmt_t;

	localparam logic [CfgIdxW-1:0] REG_SRC = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_DST = 1'b1;

	typedef enum logic [3:0] {
		OP_COPY8, OP_COPY16, OP_COPY32, OP_SX8_16, OP_SX8_32, OP_SX16_32,
		OP_I2F, OP_H2F, OP_F2I, OP_F2H, OP_UNSUP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       last;
	} ctl_t;

	function automatic op_t decode_op(input fmt_t st, input fmt_t dt);
		op_t o;
		o = OP_UNSUP;
		if (st == dt) begin
			case (st)
				T_U8, T_I8: o = OP_COPY8;
				T_U16, T_I16, T_F16: o = OP_COPY16;
				default: o = OP_COPY32;
			endcase
		end else if (st == T_U8 && (dt == T_U16 || dt == T_U32 || dt == T_I32)) begin
			o = OP_COPY8;
		end else if (st == T_I8 && dt == T_I16) begin
			o = OP_SX8_16;
		end else if (st == T_I8 && dt == T_I32) begin
			o = OP_SX8_32;
		end else if (st == T_I8 && dt == T_F32) begin
			o = OP_I2F;
		end else if (st == T_I16 && dt == T_I32) begin
			o = OP_SX16_32;
		end else if (st == T_I32 && dt == T_I8) begin
			o = OP_COPY8;
		end else if (st == T_I32 && dt == T_F32) begin
			o = OP_I2F;
		end else if (st == T_F16 && dt == T_F32) begin
			o = OP_H2F;
		end else if (st == T_F32 && dt == T_I32) begin
			o = OP_F2I;
		end else if (st == T_F32 && dt == T_F16) begin
			o = OP_F2H;
		end
		return o;
	endfunction

	// Position of the highest set bit, 0 when none.
	function automatic logic [4:0] msb_pos(input logic [31:0] v);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction
endpackage

// File: sv/ntc_stream_if.sv
// Valid/ready stream interfaces for the input and result words.
interface ntc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] in_bits;
	logic        in_last;
	modport source(output valid, in_bits, in_last, input ready);
	modport sink(input valid, in_bits, in_last, output ready);
endinterface

interface ntc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_bits;
	logic        out_last;
	logic        unsupported;
	logic        out_of_range;
	modport source(output valid, out_bits, out_last, unsupported, out_of_range, input ready);
	modport sink(input valid, out_bits, out_last, unsupported, out_of_range, output ready);
endinterface

interface ntc_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [2:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/ntc_cfg_regs.sv
// Source and destination type registers.
module ntc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	ntc_cfg_if.sink cfg,
	output ntc_pkg::fmt_t src_type,
	output ntc_pkg::fmt_t dst_type
);
	import ntc_pkg::*;
	fmt_t src_q, dst_q;

	assign cfg.ready = 1'b1;
	assign src_type = src_q;
	assign dst_type = dst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= T_F32;
			dst_q <= T_F32;
		end else if (cfg.valid) begin
			if (cfg.index == REG_SRC) src_q <= fmt_t'(cfg.data);
			else dst_q <= fmt_t'(cfg.data);
		end
	end
endmodule

// File: sv/ntc_datapath.sv
// Three-stage conversion pipeline: decode/normalize, shift, round/pack.
module ntc_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ntc_pkg::fmt_t src_type,
	input  ntc_pkg::fmt_t dst_type,
	ntc_in_if.sink  in_ch,
	ntc_out_if.source out_ch
);
	import ntc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3 = !v_s3 || out_ch.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	// Stage 1: sign handling, magnitude and leading one.
	ctl_t ctl_s1;
	logic [31:0] b_s1, mag_s1;
	logic sgn_s1;
	logic [4:0] p_s1;

	ctl_t c1;
	logic [31:0] m1;
	logic s1;
	always_comb begin
		c1.op = decode_op(src_type, dst_type);
		c1.last = in_ch.in_last;
		s1 = 1'b0;
		m1 = '0;
		if (c1.op == OP_I2F) begin
			if (src_type == T_I8) begin
				s1 = in_ch.in_bits[7];
				m1 = s1 ? 32'(-{{24{1'b1}}, in_ch.in_bits[7:0]}) : {24'd0, in_ch.in_bits[7:0]};
			end else begin
				s1 = in_ch.in_bits[31];
				m1 = s1 ? (~in_ch.in_bits + 32'd1) : in_ch.in_bits;
			end
		end else if (c1.op == OP_H2F) begin
			m1 = {22'd0, in_ch.in_bits[9:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) begin
			ctl_s1 <= c1;
			b_s1 <= in_ch.in_bits;
			mag_s1 <= m1;
			sgn_s1 <= s1;
			p_s1 <= msb_pos(m1);
		end
	end

	// Stage 2: alignment shifts.
	ctl_t ctl_s2;
	logic [31:0] b_s2, sh_s2;
	logic [31:0] rem_s2;
	logic sgn_s2;
	logic [4:0] p_s2;
	logic [8:0] aux_s2;

	logic [31:0] sh2, rem2;
	logic [8:0] aux2;
	logic [7:0] e2;
	logic [4:0] k2;
	always_comb begin
		sh2 = '0;
		rem2 = '0;
		aux2 = '0;
		e2 = b_s1[30:23];
		k2 = '0;
		case (ctl_s1.op)
			OP_I2F: begin
				if (p_s1 <= 5'd23) begin
					sh2 = mag_s1 << (5'd23 - p_s1);
				end else begin
					k2 = p_s1 - 5'd23;
					sh2 = mag_s1 >> k2;
					rem2 = (mag_s1 & ((32'd1 << k2) - 32'd1)) << (6'd32 - {1'b0, k2});
				end
			end
			OP_H2F: sh2 = mag_s1 << (5'd10 - p_s1);
			OP_F2I: begin
				if (e2 >= 8'd150) sh2 = {8'd1, b_s1[22:0]} << 5'(e2 - 8'd150);
				else if (e2 >= 8'd127) sh2 = {8'd1, b_s1[22:0]} >> 5'(8'd150 - e2);
			end
			OP_F2H: begin
				// Subnormal result: shift amount -ex-1 in range 14..24.
				if (e2 < 8'd113 && e2 >= 8'd102) begin
					k2 = 5'(8'd126 - e2);
					sh2 = {8'd1, b_s1[22:0]} >> k2;
					rem2 = ({8'd1, b_s1[22:0]} & ((32'd1 << k2) - 32'd1)) << (6'd32 - {1'b0, k2});
				end
			end
			default: ;
		endcase
		aux2 = {1'b0, e2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			ctl_s2 <= ctl_s1;
			b_s2 <= b_s1;
			sh_s2 <= sh2;
			rem_s2 <= rem2;
			sgn_s2 <= sgn_s1;
			p_s2 <= p_s1;
			aux_s2 <= aux2;
		end
	end

	// Stage 3: rounding and packing.
	logic [31:0] r3;
	logic oor3, uns3;
	logic [24:0] mant3;
	logic [7:0] ex3;
	logic [15:0] hv3;
	logic [31:0] hv32;
	logic [7:0] e3;
	always_comb begin
		r3 = '0;
		oor3 = 1'b0;
		uns3 = 1'b0;
		mant3 = '0;
		ex3 = '0;
		hv3 = '0;
		hv32 = '0;
		e3 = aux_s2[7:0];
		case (ctl_s2.op)
			OP_COPY8: r3 = {24'd0, b_s2[7:0]};
			OP_COPY16: r3 = {16'd0, b_s2[15:0]};
			OP_COPY32: r3 = b_s2;
			OP_SX8_16: r3 = {16'd0, {8{b_s2[7]}}, b_s2[7:0]};
			OP_SX8_32: r3 = {{24{b_s2[7]}}, b_s2[7:0]};
			OP_SX16_32: r3 = {{16{b_s2[15]}}, b_s2[15:0]};
			OP_I2F: begin
				mant3 = {1'b0, sh_s2[23:0]};
				ex3 = 8'd127 + {3'd0, p_s2};
				if (rem_s2[31] && (rem_s2[30:0] != '0 || sh_s2[0])) mant3 = mant3 + 25'd1;
				if (mant3[24]) begin
					mant3 = mant3 >> 1;
					ex3 = ex3 + 8'd1;
				end
				if (sh_s2 == '0) r3 = '0;
				else r3 = {sgn_s2, ex3, mant3[22:0]};
			end
			OP_H2F: begin
				if (b_s2[14:10] == 5'd0) begin
					if (b_s2[9:0] == '0) r3 = {b_s2[15], 31'd0};
					else r3 = {b_s2[15], 8'(8'd103 + {3'd0, p_s2}), sh_s2[9:0], 13'd0};
				end else if (b_s2[14:10] == 5'd31) begin
					r3 = {b_s2[15], 8'hFF, b_s2[9:0], 13'd0};
				end else begin
					r3 = {b_s2[15], 8'({3'd0, b_s2[14:10]} + 8'd112), b_s2[9:0], 13'd0};
				end
			end
			OP_F2I: begin
				if (e3 == 8'hFF && b_s2[22:0] != '0) begin
					oor3 = 1'b1;
				end else if (e3 < 8'd127) begin
					r3 = '0;
				end else if (e3 >= 8'd158) begin
					if (b_s2[31] && e3 == 8'd158 && b_s2[22:0] == '0) begin
						r3 = 32'h8000_0000;
					end else begin
						oor3 = 1'b1;
						r3 = b_s2[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					end
				end else begin
					r3 = b_s2[31] ? (~sh_s2 + 32'd1) : sh_s2;
				end
			end
			OP_F2H: begin
				if (e3 == 8'hFF) begin
					if (b_s2[22:0] != '0) hv3 = {b_s2[31], 5'h1F, 1'b1, b_s2[21:13]};
					else hv3 = {b_s2[31], 15'h7C00};
				end else if (e3 == 8'd0 || e3 < 8'd102) begin
					hv3 = {b_s2[31], 15'd0};
				end else if (e3 > 8'd142) begin
					hv3 = {b_s2[31], 15'h7C00};
				end else if (e3 >= 8'd113) begin
					hv32 = {17'd0, 5'(e3 - 8'd112), b_s2[22:13]};
					if (b_s2[12:0] > 13'h1000 || (b_s2[12:0] == 13'h1000 && hv32[0]))
						hv32 = hv32 + 32'd1;
					hv3 = {b_s2[31], hv32[14:0]};
				end else begin
					hv32 = sh_s2;
					if (rem_s2[31] && (rem_s2[30:0] != '0 || sh_s2[0])) hv32 = hv32 + 32'd1;
					hv3 = {b_s2[31], hv32[14:0]};
				end
				r3 = {16'd0, hv3};
			end
			default: uns3 = 1'b1;
		endcase
	end

	logic [31:0] r_s3;
	logic last_s3, uns_s3, oor_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			r_s3 <= r3;
			last_s3 <= ctl_s2.last;
			uns_s3 <= uns3;
			oor_s3 <= oor3;
		end
	end

	assign out_ch.valid = v_s3;
	assign out_ch.out_bits = r_s3;
	assign out_ch.out_last = last_s3;
	assign out_ch.unsupported = uns_s3;
	assign out_ch.out_of_range = oor_s3;
endmodule

// File: sv/numeric_type_converter.sv
// Top level of the numeric type converter.
// The converter takes one word per cycle and delivers its result through a three-stage
// pipeline: the first stage decodes the type pair and finds the magnitude and leading
// one, the second aligns the significand, the third rounds and packs the result word.
// Sustained rate is one word per cycle while the sink is ready; a stall holds every
// occupied stage in place. The type registers reset to f32 to f32 (a copy) and are
// written via the configuration channel, index 0 for the source format and index 1 for the
// destination format. The user must write them only while the pipeline is empty; the block does not check this.
module numeric_type_converter (
	input  logic clk,
	input  logic arst_n,
	ntc_cfg_if.sink cfg,
	ntc_in_if.sink in_ch,
	ntc_out_if.source out_ch
);
	import ntc_pkg::*;

	fmt_t src_type, dst_type;

	// Configuration registers.
	ntc_cfg_regs u_regs (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.src_type(src_type), .dst_type(dst_type)
	);

	// Conversion pipeline.
	ntc_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.src_type(src_type), .dst_type(dst_type),
		.in_ch(in_ch), .out_ch(out_ch)
	);
endmodule

// File: sv/ntc_checker.sv
// Port-level checker for the converter, bound to the top level.
module ntc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_bits,
	input logic unsupported,
	input logic out_of_range
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("result word changed under stall");
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> out_bits == 32'd0 && !out_of_range)
		else $error("unsupported word is not zero");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(unsupported && out_of_range))
		else $error("both flags set");
endmodule

bind numeric_type_converter ntc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_bits(out_ch.out_bits), .unsupported(out_ch.unsupported),
	.out_of_range(out_ch.out_of_range)
);

// File: tb/ntc_tb_if.sv
// Note: the interfaces come from the RTL file sv/ntc_stream_if.sv; this file holds shared testbench types.
`timescale 1ns / 100ps
package ntc_tb_pkg;
	typedef struct packed {
		logic [31:0] bits;
		logic        last;
		logic        unsup;
		logic        oor;
	} conv_word_t;
endpackage

// File: tb/tb.sv
// Testbench for the numeric type converter: directed and random words checked against a predictor.
`timescale 1ns / 100ps
module tb;
	import ntc_pkg::*;
	import ntc_tb_pkg::*;

	logic clk;
	logic arst_n;
	logic failed;
	logic rx_hold;     // When set, the receiver holds ready low.
	logic rx_random;   // When clear, the receiver is always ready.
	logic tx_random;   // When clear, the sender never idles between words.

	ntc_cfg_if cfg ();
	ntc_in_if  in_ch ();
	ntc_out_if out_ch ();

	numeric_type_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.in_ch(in_ch.source),
		.out_ch(out_ch.sink)
	);

	// Current type registers as the predictor sees them.
	fmt_t cur_src;
	fmt_t cur_dst;

	// Converted words that the block still owes us, oldest first.
	conv_word_t pending_words[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random gap length: mostly short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Signed integer to f32, rounding to nearest even.
	function automatic logic [31:0] int_to_float(input logic [31:0] v);
		logic        sgn;
		logic [31:0] mag;
		logic [31:0] rem;
		logic [31:0] half;
		logic [31:0] mant;
		int          p;
		int          ex;
		int          sh;
		sgn = v[31];
		mag = sgn ? -v : v;
		if (mag == 0) return 32'h0;
		p = 31;
		while (!mag[p]) p--;
		ex = 127 + p;
		if (p <= 23) begin
			mant = mag << (23 - p);
		end else begin
			sh = p - 23;
			rem = mag & ((32'd1 << sh) - 1);
			half = 32'd1 << (sh - 1);
			mant = mag >> sh;
			if (rem > half || (rem == half && mant[0])) mant++;
			if (mant == 32'h0100_0000) begin
				mant = mant >> 1;
				ex++;
			end
		end
		return {sgn, 8'(ex), mant[22:0]};
	endfunction

	// f16 to f32 is exact; subnormals are normalized.
	function automatic logic [31:0] half_to_float(input logic [15:0] h);
		logic [4:0] ex;
		logic [9:0] fr;
		logic [10:0] f;
		int          e2;
		ex = h[14:10];
		fr = h[9:0];
		if (ex == 0) begin
			if (fr == 0) return {h[15], 31'h0};
			f = {1'b0, fr};
			e2 = 1;
			while (!f[10]) begin
				f = f << 1;
				e2--;
			end
			return {h[15], 8'(e2 + 112), f[9:0], 13'h0};
		end
		if (ex == 5'h1f) return {h[15], 8'hff, fr, 13'h0};
		return {h[15], 8'(ex + 112), fr, 13'h0};
	endfunction

	// f32 to i32, truncating toward zero; saturation and NaN raise the flag.
	function automatic logic [32:0] float_to_int(input logic [31:0] b);
		logic [7:0]  ex;
		logic [22:0] m;
		logic [31:0] val;
		int          e2;
		ex = b[30:23];
		m = b[22:0];
		if (ex == 8'hff && m != 0) return {1'b1, 32'h0};
		e2 = int'(ex) - 127;
		if (e2 < 0) return 33'h0;
		if (e2 >= 31) begin
			// Exactly -2^31 fits without saturation.
			if (b[31] && e2 == 31 && m == 0) return {1'b0, 32'h8000_0000};
			return {1'b1, b[31] ? 32'h8000_0000 : 32'h7fff_ffff};
		end
		val = {9'h1, m};
		if (e2 >= 23) val = val << (e2 - 23);
		else val = val >> (23 - e2);
		return {1'b0, b[31] ? -val : val};
	endfunction

	// f32 to f16 with round to nearest even, including subnormal results.
	function automatic logic [15:0] float_to_half(input logic [31:0] b);
		logic [15:0] s;
		logic [7:0]  ex;
		logic [22:0] m;
		logic [31:0] val;
		logic [31:0] sig;
		logic [31:0] rem;
		logic [31:0] half;
		int          e2;
		int          sh;
		s = {b[31], 15'h0};
		ex = b[30:23];
		m = b[22:0];
		if (ex == 8'hff) begin
			// A NaN stays quiet and keeps its top payload bits.
			if (m != 0) return s | 16'h7e00 | 16'(m >> 13);
			return s | 16'h7c00;
		end
		if (ex == 0) return s;
		e2 = int'(ex) - 127;
		if (e2 > 15) return s | 16'h7c00;
		if (e2 >= -14) begin
			val = (32'(e2 + 15) << 10) | (m >> 13);
			rem = m & 23'h1fff;
			if (rem > 32'h1000 || (rem == 32'h1000 && val[0])) val++;
			return s | val[15:0];
		end
		if (e2 < -25) return s;
		sig = {9'h1, m};
		sh = -e2 - 1;
		val = sig >> sh;
		rem = sig & ((32'd1 << sh) - 1);
		half = 32'd1 << (sh - 1);
		if (rem > half || (rem == half && val[0])) val++;
		return s | val[15:0];
	endfunction

	// Predicts the converted word for one input word under the current types.
	function automatic conv_word_t convert_word(input logic [31:0] b, input logic last);
		conv_word_t w;
		logic [32:0] fi;
		w = '0;
		w.last = last;
		if (cur_src == cur_dst) begin
			case (cur_src)
				T_U8, T_I8: w.bits = {24'h0, b[7:0]};
				T_U16, T_I16, T_F16: w.bits = {16'h0, b[15:0]};
				default: w.bits = b;
			endcase
		end else if (cur_src == T_U8 && (cur_dst == T_U16 || cur_dst == T_U32 ||
				cur_dst == T_I32)) begin
			w.bits = {24'h0, b[7:0]};
		end else if (cur_src == T_I8 && cur_dst == T_I16) begin
			w.bits = {16'h0, {8{b[7]}}, b[7:0]};
		end else if (cur_src == T_I8 && cur_dst == T_I32) begin
			w.bits = {{24{b[7]}}, b[7:0]};
		end else if (cur_src == T_I8 && cur_dst == T_F32) begin
			w.bits = int_to_float({{24{b[7]}}, b[7:0]});
		end else if (cur_src == T_I16 && cur_dst == T_I32) begin
			w.bits = {{16{b[15]}}, b[15:0]};
		end else if (cur_src == T_I32 && cur_dst == T_I8) begin
			w.bits = {24'h0, b[7:0]};
		end else if (cur_src == T_I32 && cur_dst == T_F32) begin
			w.bits = int_to_float(b);
		end else if (cur_src == T_F16 && cur_dst == T_F32) begin
			w.bits = half_to_float(b[15:0]);
		end else if (cur_src == T_F32 && cur_dst == T_I32) begin
			fi = float_to_int(b);
			w.bits = fi[31:0];
			w.oor = fi[32];
		end else if (cur_src == T_F32 && cur_dst == T_F16) begin
			w.bits = {16'h0, float_to_half(b)};
		end else begin
			w.unsup = 1'b1;
		end
		return w;
	endfunction

	// Sends one word; the prediction is queued when the block accepts it.
	// Valid stays high after acceptance so that the next word can follow with no
	// gap; whoever stops sending drops valid at the next falling edge.
	task automatic send_word(input logic [31:0] b, input logic last);
		int g;
		g = tx_random ? gap_len() : 0;
		@(negedge clk);
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_bits <= b;
		in_ch.in_last <= last;
		do @(posedge clk); while (!in_ch.ready);
		pending_words.push_back(convert_word(b, last));
	endtask

	// Stops sending, waits until every predicted word is back, then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Writes one type register; only called with the block idle.
	task automatic write_type(input logic [CfgIdxW-1:0] idx, input fmt_t f);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= f;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_SRC) cur_src = f;
		else cur_dst = f;
	endtask

	task automatic set_pair(input fmt_t s, input fmt_t d);
		drain();
		write_type(REG_SRC, s);
		write_type(REG_DST, d);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Random value biased toward special encodings for the source type.
	function automatic logic [31:0] pick_value(input fmt_t s);
		logic [31:0] r;
		int k;
		r = $urandom();
		k = $urandom_range(0, 9);
		if (s == T_F32) begin
			case (k)
				0: r[30:23] = 8'hff;
				1: r[30:23] = 8'h00;
				2: r[30:23] = 8'(158 + $urandom_range(0, 1));
				3: r[30:23] = 8'($urandom_range(100, 114));
				4: r[12:0] = 13'h1000;
				5: r[30:23] = 8'($urandom_range(112, 143));
				default: r[30:23] = 8'($urandom_range(110, 160));
			endcase
		end else if (s == T_F16) begin
			if (k == 0) r[14:10] = 5'h1f;
			else if (k == 1) r[14:10] = 5'h00;
		end else if (k == 0) begin
			r = {$urandom_range(0, 1) ? 8'hff : 8'h00, r[23:0]};
		end
		return r;
	endfunction

	// Checks every word the block hands back against the oldest prediction.
	always @(posedge clk) begin
		conv_word_t exp_w;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word bits=%h", $time, out_ch.out_bits);
				failed = 1'b1;
			end else begin
				exp_w = pending_words.pop_front();
				if (out_ch.out_bits !== exp_w.bits || out_ch.out_last !== exp_w.last ||
						out_ch.unsupported !== exp_w.unsup ||
						out_ch.out_of_range !== exp_w.oor) begin
					$display("%0t: mismatch expected bits=%h last=%b unsup=%b oor=%b",
						$time, exp_w.bits, exp_w.last, exp_w.unsup, exp_w.oor);
					$display("%0t:          actual   bits=%h last=%b unsup=%b oor=%b",
						$time, out_ch.out_bits, out_ch.out_last, out_ch.unsupported,
						out_ch.out_of_range);
					failed = 1'b1;
				end
			end
		end
	end

	// Receiver: ready toggles with random stalls, or is held low on request.
	initial begin
		int g;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ch.ready <= 1'b0;
			end else if (!rx_random) begin
				out_ch.ready <= 1'b1;
			end else begin
				g = gap_len();
				if (g == 0) begin
					out_ch.ready <= 1'b1;
				end else begin
					out_ch.ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// Reset-state copy, then special cases of the pairs that involve floats, and one unsupported pair.
	task automatic test_directed();
		send_word(32'hdead_beef, 1'b0);
		set_pair(T_F32, T_I32);
		send_word(32'h7fc0_0000, 1'b0);   // NaN gives zero with the flag
		send_word(32'h4f00_0000, 1'b0);   // 2^31 saturates high
		send_word(32'hcf00_0000, 1'b0);   // exactly -2^31, no flag
		send_word(32'hcf00_0001, 1'b0);   // below -2^31 saturates low
		send_word(32'hbfc0_0000, 1'b1);   // -1.5 truncates to -1
		set_pair(T_F32, T_F16);
		send_word(32'hffc0_1234, 1'b0);   // NaN keeps sign and payload
		send_word(32'h7f80_0000, 1'b0);
		send_word(32'h4780_0000, 1'b0);   // 65536 overflows to infinity
		send_word(32'h3380_0000, 1'b0);   // 2^-24 is the smallest subnormal
		send_word(32'h3300_0001, 1'b0);   // just above half of it rounds up
		send_word(32'h3f80_1000, 1'b0);   // tie rounds to even
		send_word(32'h8000_0001, 1'b1);   // input subnormal becomes signed zero
		set_pair(T_I32, T_F32);
		send_word(32'h7fff_ffff, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h0100_0001, 1'b1);
		set_pair(T_F16, T_F32);
		send_word(32'hffff_0001, 1'b0);
		send_word(32'h0000_fc01, 1'b1);
		set_pair(T_I8, T_F32);
		send_word(32'h0000_0080, 1'b0);
		set_pair(T_U16, T_F16);
		send_word(32'hffff_ffff, 1'b1);   // unsupported pair
	endtask

	// Random words over every type pair, including the extremes of the codes.
	task automatic test_random_pairs();
		fmt_t s;
		fmt_t d;
		int n;
		for (int p = 0; p < 64; p++) begin
			s = fmt_t'(p / 8);
			d = fmt_t'(p % 8);
			set_pair(s, d);
			rx_random = (p % 5 != 0);
			tx_random = (p % 7 != 0);
			n = (s == T_F32 || s == T_I32 || s == T_F16 || s == T_I8) ? 30 : 16;
			for (int i = 0; i < n; i++)
				send_word(pick_value(s), 1'($urandom_range(0, 1)));
		end
		rx_random = 1'b1;
		tx_random = 1'b1;
	endtask

	// Receiver stalls for a long stretch while words keep coming, so the input backs up.
	task automatic test_backpressure();
		set_pair(T_F32, T_F16);
		fork
			begin
				rx_hold = 1'b1;
				repeat (60) @(negedge clk);
				rx_hold = 1'b0;
			end
			for (int i = 0; i < 40; i++)
				send_word(pick_value(T_F32), 1'($urandom_range(0, 1)));
		join
		// Sender pauses until every word has come back, then resumes.
		drain();
		for (int i = 0; i < 20; i++)
			send_word(pick_value(T_F32), 1'b0);
	endtask

	initial begin
		failed = 1'b0;
		rx_hold = 1'b0;
		rx_random = 1'b1;
		tx_random = 1'b1;
		cur_src = T_F32;
		cur_dst = T_F32;
		in_ch.valid = 1'b0;
		in_ch.in_bits = '0;
		in_ch.in_last = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_pairs();
		test_backpressure();
		drain();
		if (!failed) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: sim.f
sv/ntc_pkg.sv
sv/ntc_stream_if.sv
sv/ntc_cfg_regs.sv
sv/ntc_datapath.sv
sv/numeric_type_converter.sv
sv/ntc_checker.sv
tb/ntc_tb_if.sv
tb/tb.sv
